// ===== design/pvfp_pkg.sv =====
`default_nettype none
package pvfp_pkg;

  typedef enum logic [1:0] {
    DT_FLOAT32 = 2'd0,
    DT_BFLOAT16 = 2'd1,
    DT_UINT16 = 2'd2,
    DT_INT = 2'd3
  } data_type_e;

  localparam logic [15:0] Bf16Qnan = 16'h7FC0;
  localparam logic [31:0] BfRoundBias = 32'h0000_7FFF;
  localparam logic [31:0] U16MaxBits = 32'h477F_FF00;
  localparam logic [31:0] U16JustBelowHalf = 32'h3EFF_FFFF;
  localparam logic [15:0] U16Sat = 16'hFFFF;
  localparam logic [31:0] IntPosSat = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// ===== design/pvfp_conv.sv =====
`default_nettype none
module pvfp_conv (
  input  wire logic [1:0]  data_type_i,
  input  wire logic [31:0] value_bits_i,
  output logic      [31:0] packed_word_o
);

  logic [7:0]  exp_w;
  logic [22:0] man_w;
  logic        nan_w;
  logic        zero_w;
  logic [23:0] sig_w;

  assign exp_w  = value_bits_i[30:23];
  assign man_w  = value_bits_i[22:0];
  assign nan_w  = (exp_w == 8'hFF) && (man_w != 23'd0);
  assign zero_w = (value_bits_i[30:0] == 31'd0);
  assign sig_w  = {1'b1, man_w};

  // bfloat16, round to nearest even
  logic [31:0] bf_sum;
  logic [15:0] bf_res;
  assign bf_sum = value_bits_i + pvfp_pkg::BfRoundBias + {31'd0, value_bits_i[16]};
  assign bf_res = nan_w ? pvfp_pkg::Bf16Qnan : bf_sum[31:16];

  // uint16: floor of float32 (v + 0.5), sum held in units of 2^-24
  logic [7:0]  u_sh8;
  logic [4:0]  u_sh;
  logic [40:0] u_s;
  logic        u_hi;
  logic [4:0]  u_d;
  logic [40:0] u_q;
  logic [40:0] u_mask;
  logic [40:0] u_r;
  logic [40:0] u_hb;
  logic        u_up;
  logic [40:0] u_qr;
  logic [40:0] u_fin;
  logic [15:0] u_res;

  always_comb begin
    u_sh8  = exp_w - 8'd126;
    u_sh   = u_sh8[4:0];
    u_s    = ({17'd0, sig_w} << u_sh) + 41'h80_0000;
    u_hi   = u_s[6'(u_sh) + 6'd24];
    u_d    = u_sh + {4'd0, u_hi};
    u_q    = u_s >> u_d;
    u_mask = (41'd1 << u_d) - 41'd1;
    u_r    = u_s & u_mask;
    u_hb   = u_mask ^ (u_mask >> 1);
    u_up   = (u_d != 5'd0) && ((u_r > u_hb) || ((u_r == u_hb) && u_q[0]));
    u_qr   = u_q + {40'd0, u_up};
    u_fin  = (u_qr << u_d) >> 24;
    if (value_bits_i[31] || nan_w) begin
      u_res = 16'd0;
    end else if (value_bits_i >= pvfp_pkg::U16MaxBits) begin
      u_res = pvfp_pkg::U16Sat;
    end else if (exp_w < 8'd126) begin
      u_res = (value_bits_i == pvfp_pkg::U16JustBelowHalf) ? 16'd1 : 16'd0;
    end else begin
      u_res = u_fin[15:0];
    end
  end

  // integer: truncate toward zero, keep low word; from 2^63 up, all ones if positive, zero if negative
  logic [7:0]  i_e;
  logic [95:0] i_shl;
  logic [31:0] i_mag;
  logic [31:0] i_res;

  always_comb begin
    i_e   = exp_w - 8'd127;
    i_shl = ({72'd0, sig_w} << i_e[5:0]) >> 23;
    i_mag = i_shl[31:0];
    if (nan_w || (exp_w < 8'd127)) begin
      i_res = 32'd0;
    end else if (exp_w >= 8'd190) begin
      i_res = value_bits_i[31] ? 32'd0 : pvfp_pkg::IntPosSat;
    end else begin
      i_res = value_bits_i[31] ? (32'd0 - i_mag) : i_mag;
    end
  end

  always_comb begin
    if (zero_w) begin
      packed_word_o = 32'd0;
    end else begin
      case (pvfp_pkg::data_type_e'(data_type_i))
        pvfp_pkg::DT_FLOAT32:  packed_word_o = value_bits_i;
        pvfp_pkg::DT_BFLOAT16: packed_word_o = {bf_res, bf_res};
        pvfp_pkg::DT_UINT16:   packed_word_o = {u_res, u_res};
        pvfp_pkg::DT_INT:      packed_word_o = i_res;
        default:               packed_word_o = {bf_res, bf_res};
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/pad_value_format_packer.sv =====
// Stages: input register, then result register.
// Throughput: one item per cycle while the output is not stalled; conversion logic sits between the two registers.
// A stall on the output holds both stages and backs up onto in_stall_o.
// Reset (rst_ni low, asynchronous) empties both stages; payload registers are not reset.
`default_nettype none
module pad_value_format_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  data_type_i,
  input  wire logic [31:0] value_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [31:0] packed_word_o
);

  logic        in_valid_q;
  logic [1:0]  type_q;
  logic [31:0] bits_q;
  logic        out_valid_q;
  logic [31:0] word_q;
  logic [31:0] word_d;
  logic        out_en;
  logic        in_en;

  assign out_en     = !out_valid_q || !out_stall_i;
  assign in_en      = !in_valid_q || out_en;
  assign in_stall_o = !in_en;

  pvfp_conv u_conv (
    .data_type_i  (type_q),
    .value_bits_i (bits_q),
    .packed_word_o(word_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_en) in_valid_q <= in_valid_i;
      if (out_en) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && in_valid_i) begin
      type_q <= data_type_i;
      bits_q <= value_bits_i;
    end
    if (out_en && in_valid_q) word_q <= word_d;
  end

  assign out_valid_o   = out_valid_q;
  assign packed_word_o = word_q;

endmodule
`default_nettype wire

// ===== design/pvfp_checker.sv =====
`default_nettype none
module pvfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] packed_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(packed_word_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_stall_o && in_valid_i |=> ##1 out_valid_o)
    else $error("transfer into empty block gave no result");

endmodule

bind pad_value_format_packer pvfp_checker u_pvfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .packed_word_o(packed_word_o)
);
`default_nettype wire

// ===== bench/pad_value_format_packer_checker.sv =====
module pad_value_format_packer_checker
  import pvfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [1:0]  data_type_i,
  input  wire logic [31:0] value_bits_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [31:0] packed_word_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] fill_words_q[$];

  function automatic logic [31:0] dup_half(logic [15:0] h);
    return {h, h};
  endfunction

  function automatic logic [31:0] bf16_fill(logic [31:0] bits);
    logic [31:0] sum;
    if (bits[30:23] == 8'hFF && bits[22:0] != '0) return dup_half(Bf16Qnan);
    sum = bits + BfRoundBias + {31'd0, bits[16]};
    return dup_half(sum[31:16]);
  endfunction

  // exact value+0.5 in units of 2^-24, then round to 24 significant bits
  function automatic logic [31:0] u16_fill(logic [31:0] bits);
    int e, len, d;
    logic [63:0] s, q, r, hb;
    if (bits[31] || (bits[30:23] == 8'hFF && bits[22:0] != '0)) return '0;
    if (bits >= U16MaxBits) return dup_half(U16Sat);
    e = int'(bits[30:23]) - 127;
    if (e < -1) return (bits == U16JustBelowHalf) ? dup_half(16'd1) : '0;
    s = ({40'd0, 1'b1, bits[22:0]} << (e + 1)) + (64'd1 << 23);
    len = 0;
    for (q = s; q != 0; q >>= 1) len++;
    d = len - 24;
    if (d > 0) begin
      q = s >> d;
      r = s & ((64'd1 << d) - 1);
      hb = 64'd1 << (d - 1);
      if (r > hb || (r == hb && q[0])) q++;
      s = q << d;
    end
    return dup_half(s[39:24]);
  endfunction

  function automatic logic [31:0] int_fill(logic [31:0] bits);
    int e;
    logic [63:0] mag;
    if (bits[30:23] == 8'hFF && bits[22:0] != '0) return '0;
    e = int'(bits[30:23]) - 127;
    if (e < 0) return '0;
    if (e >= 63) return bits[31] ? '0 : IntPosSat;
    mag = {40'd0, 1'b1, bits[22:0]};
    if (e >= 23) mag = mag << (e - 23);
    else mag = mag >> (23 - e);
    if (bits[31]) mag = -mag;
    return mag[31:0];
  endfunction

  function automatic logic [31:0] fill_word(data_type_e dt, logic [31:0] bits);
    if (bits[30:0] == '0) return '0;
    case (dt)
      DT_FLOAT32:  return bits;
      DT_BFLOAT16: return bf16_fill(bits);
      DT_UINT16:   return u16_fill(bits);
      default:     return int_fill(bits);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  assign pending_o = fill_words_q.size();

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        fill_words_q = {fill_words_q, fill_word(data_type_e'(data_type_i), value_bits_i)};
      if (out_valid_i && !out_stall_i) begin
        if (fill_words_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", packed_word_i));
        end else begin
          if (packed_word_i !== fill_words_q[0])
            report_mismatch($sformatf("packed_word %h, expected %h",
                                      packed_word_i, fill_words_q[0]));
          void'(fill_words_q.pop_front());
        end
      end
    end
  end
endmodule

// ===== bench/pad_value_format_packer_tb.sv =====
module pad_value_format_packer_tb;
  import pvfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, out_stall = 1'b0;
  logic [1:0] data_type = DT_FLOAT32;
  logic [31:0] value_bits = '0;
  logic in_stall, out_valid;
  logic [31:0] packed_word;
  int fail_count, pending, cycles = 0;
  int out_wait = 0;
  bit stall_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  pad_value_format_packer dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .data_type_i(data_type), .value_bits_i(value_bits), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .packed_word_o(packed_word)
  );

  pad_value_format_packer_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .data_type_i(data_type), .value_bits_i(value_bits), .out_valid_i(out_valid),
    .out_stall_i(out_stall), .packed_word_i(packed_word),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: draw the wait before the next transfer at each transfer
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      out_wait = stall_on ? $urandom_range(0, 11) : 0;
  end

  always @(negedge clk) begin
    if (rst_n && out_wait > 0) begin
      out_stall <= 1'b1;
      out_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_value(data_type_e dt, logic [31:0] bits, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_type <= dt;
    value_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] v = $urandom;
    case ($urandom_range(0, 5))
      0: v[30:23] = 8'(127 + $urandom_range(0, 18));        // uint16 range
      1: v[30:23] = 8'(120 + $urandom_range(0, 70));        // integer range
      2: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;   // inf, NaN, subnormal
      3: v[15:0] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF; // rounding ties
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] directed[] = '{32'h0000_0000, 32'h8000_0000, 32'h7FC0_0001,
      32'hFFFF_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h3EFF_FFFF,
      32'h3F00_0000, 32'h477F_FF00, 32'h477F_FEFF, 32'hBF80_0000, 32'h5F00_0000,
      32'hDF00_0000, 32'h0000_0001, 32'h3F80_8000, 32'h4F00_0000, 32'h3FC0_0000};
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i])
      for (int t = 0; t < 4; t++) send_value(data_type_e'(t), directed[i], 0);
    for (n = 0; n < 1000; n++) begin
      stall_on = (n / 200) % 2 == 0;
      send_value(data_type_e'($urandom_range(0, 3)), random_value(),
                 (stall_on ? $urandom_range(0, 11) : 0));
    end
    in_valid <= 1'b0;
    stall_on = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/pvfp_pkg.sv
design/pvfp_conv.sv
design/pad_value_format_packer.sv
design/pvfp_checker.sv
bench/pad_value_format_packer_checker.sv
bench/pad_value_format_packer_tb.sv
